// ----- rtl/dbc_pkg.sv -----
`default_nettype none

package dbc_pkg;

   localparam int unsigned WORD_BITS = 64;
   localparam int unsigned WIN_BITS  = 6;
   localparam int unsigned LEAD_POS  = WORD_BITS - WIN_BITS;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [WIN_BITS-1:0]  rot_type;

   // six-bit cyclic window whose least significant bit is word bit start
   function automatic rot_type window_at(input word_type word, input rot_type start);
      logic [2*WORD_BITS-1:0] dbl;
      dbl = {word, word} >> start;
      return dbl[WIN_BITS-1:0];
   endfunction

   function automatic word_type rotate_right(input word_type word, input rot_type amt);
      logic [2*WORD_BITS-1:0] dbl;
      dbl = {word, word} >> amt;
      return dbl[WORD_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/de_bruijn_b2_6_canonicalize_top.sv -----
// Path: a req_ transaction is accepted into the input register, moves on into the result register
// once that register is free, and rsp_valid rises when the result register is loaded.
// Throughput: one transaction per cycle; while a result waits for rsp_stall to drop, one more
// word is taken into the input register, after which req_stall rises.
// Each word is checked in one pass of window decode, coverage OR and rotate logic.
// Reset (synchronous, active high) clears both stage valid flags; payload registers hold.
`default_nettype none

module de_bruijn_b2_6_canonicalize_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [dbc_pkg::WORD_BITS-1:0] req_word,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [dbc_pkg::WORD_BITS-1:0] rsp_canonical,
   output      logic [dbc_pkg::WIN_BITS-1:0]  rsp_rotation,
   output      logic                          rsp_is_valid
);

   logic               in_valid_ff;
   logic               in_valid_in;
   dbc_pkg::word_type  in_word_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   dbc_pkg::word_type  out_canonical_ff;
   dbc_pkg::word_type  out_canonical_in;
   dbc_pkg::rot_type   out_rotation_ff;
   dbc_pkg::rot_type   out_rotation_in;
   logic               out_is_valid_ff;
   logic               out_is_valid_in;

   logic               out_free;
   logic               in_move;
   logic               req_take;

   dbc_pkg::word_type  seen;
   dbc_pkg::rot_type   zero_rot;
   dbc_pkg::rot_type   win;
   logic               pass;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !in_move);
      out_valid_in = in_move || (out_valid_ff && rsp_stall);
   end

   // 64 windows are distinct exactly when every one of the 64 values is hit
   always_comb begin
      seen     = '0;
      zero_rot = '0;
      win      = '0;
      for (int s = 0; s < dbc_pkg::WORD_BITS; s++) begin
         win  = dbc_pkg::window_at(in_word_ff, dbc_pkg::WIN_BITS'(s));
         seen = seen | (dbc_pkg::word_type'(1) << win);
         if (win == '0) begin
            zero_rot = zero_rot | dbc_pkg::WIN_BITS'(s + dbc_pkg::WIN_BITS);
         end
      end
      pass = &seen;
      if (pass) begin
         out_rotation_in  = zero_rot;
         out_canonical_in = dbc_pkg::rotate_right(in_word_ff, zero_rot);
         out_is_valid_in  = 1'b1;
      end else begin
         out_rotation_in  = '0;
         out_canonical_in = '0;
         out_is_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (in_move) begin
         out_canonical_ff <= out_canonical_in;
         out_rotation_ff  <= out_rotation_in;
         out_is_valid_ff  <= out_is_valid_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_canonical = out_canonical_ff;
   assign rsp_rotation  = out_rotation_ff;
   assign rsp_is_valid  = out_is_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/dbc_checker.sv -----
`default_nettype none

module dbc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic [dbc_pkg::WORD_BITS-1:0] req_word,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [dbc_pkg::WORD_BITS-1:0] rsp_canonical,
   input wire logic [dbc_pkg::WIN_BITS-1:0]  rsp_rotation,
   input wire logic                          rsp_is_valid
);

   // stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_word))
      else $error("stalled req transaction changed");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_canonical)
         && $stable(rsp_rotation) && $stable(rsp_is_valid))
      else $error("stalled rsp transaction changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_valid |-> rsp_canonical == '0 && rsp_rotation == '0)
      else $error("failed check must return zero fields");

   // zero window leads the canonical word
   a_zero_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_valid
         |-> rsp_canonical[dbc_pkg::WORD_BITS-1:dbc_pkg::LEAD_POS] == '0)
      else $error("canonical word does not start with zero window");

   a_balanced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_valid |-> $countones(rsp_canonical) == dbc_pkg::WORD_BITS / 2)
      else $error("passing sequence is not balanced");

endmodule

bind de_bruijn_b2_6_canonicalize_top dbc_checker u_dbc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_word      (req_word),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_canonical (rsp_canonical),
   .rsp_rotation  (rsp_rotation),
   .rsp_is_valid  (rsp_is_valid)
);

`default_nettype wire

// ----- dv/de_bruijn_b2_6_canonicalize_top_tb.sv -----
`default_nettype none

module de_bruijn_b2_6_canonicalize_top_tb;

   typedef dbc_pkg::word_type word_type;
   typedef dbc_pkg::rot_type  rot_type;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned RANDOM_WORDS = 1250;
   localparam word_type SEQ_A = 64'h03F7_9D71_B4CB_0A89;

   typedef struct packed {
      word_type canonical;
      rot_type  rotation;
      logic     is_valid;
   } canon_result_type;

   typedef struct packed {
      word_type base;
      rot_type  turn;
      logic     invert;
      word_type flip;
      logic     typed;
      word_type canon;
      rot_type  rot;
      logic     ok;
   } stim_row_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   word_type req_word = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   word_type rsp_canonical;
   rot_type  rsp_rotation;
   logic     rsp_is_valid;

   canon_result_type canon_due [$];
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count = 0;
   int unsigned      stall_hold = 0;
   int unsigned      stall_draw = 0;
   bit               quiet = 1'b0;

   stim_row_type stim_table [17] = '{
      '{64'h0, 6'd0, 1'b0, 64'h0, 1'b1, 64'h0, 6'd0, 1'b0},
      '{64'h0, 6'd0, 1'b1, 64'h0, 1'b1, 64'h0, 6'd0, 1'b0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 6'd0, 1'b0, 64'h0, 1'b1, 64'h0, 6'd0, 1'b0},
      '{64'h5555_5555_5555_5555, 6'd0, 1'b0, 64'h0, 1'b1, 64'h0, 6'd0, 1'b0},
      '{64'h1, 6'd0, 1'b0, 64'h0, 1'b1, 64'h0, 6'd0, 1'b0},
      '{64'h8000_0000_0000_0000, 6'd0, 1'b0, 64'h0, 1'b1, 64'h0, 6'd0, 1'b0},
      '{SEQ_A, 6'd0, 1'b0, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
      '{SEQ_A, 6'd1, 1'b0, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
      '{SEQ_A, 6'd6, 1'b0, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
      '{SEQ_A, 6'd32, 1'b0, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
      '{SEQ_A, 6'd63, 1'b0, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
      '{SEQ_A, 6'd0, 1'b1, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
      '{SEQ_A, 6'd17, 1'b1, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
      '{SEQ_A, 6'd0, 1'b0, 64'h1, 1'b0, 64'h0, 6'd0, 1'b0},
      '{SEQ_A, 6'd0, 1'b0, 64'h8000_0000_0000_0000, 1'b0, 64'h0, 6'd0, 1'b0},
      '{SEQ_A, 6'd9, 1'b0, 64'h0000_0100_0000_0400, 1'b0, 64'h0, 6'd0, 1'b0},
      '{64'hFFFF_FFFF_0000_0000, 6'd0, 1'b0, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0}
   };

   de_bruijn_b2_6_canonicalize_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_canonical (rsp_canonical),
      .rsp_rotation  (rsp_rotation),
      .rsp_is_valid  (rsp_is_valid)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic word_type rotl(input word_type w, input int unsigned amt);
      int unsigned k;
      word_type r;
      for (k = 0; k < 64; k++) begin
         r[(k + amt) % 64] = w[k];
      end
      return r;
   endfunction

   // window n starts at bit (n + 58) mod 64; rotation comes from the zero window
   function automatic canon_result_type canonicalize_word(input word_type w);
      logic [63:0]      seen;
      rot_type          win;
      rot_type          rot;
      int unsigned      start;
      int unsigned      n;
      int unsigned      k;
      bit               ok;
      canon_result_type res;
      seen = '0;
      rot  = '0;
      ok   = 1'b1;
      for (n = 1; n <= 64; n++) begin
         start = (n + 58) % 64;
         for (k = 0; k < 6; k++) begin
            win[k] = w[(start + k) % 64];
         end
         if (seen[win]) begin
            ok = 1'b0;
         end
         seen[win] = 1'b1;
         if (win == 6'd0) begin
            rot = rot_type'(n % 64);
         end
      end
      res = '0;
      if (ok && seen == '1) begin
         for (k = 0; k < 64; k++) begin
            res.canonical[k] = w[(k + rot) % 64];
         end
         res.rotation = rot;
         res.is_valid = 1'b1;
      end
      return res;
   endfunction

   // random Eulerian circuit over the order-5 graph gives a random B(2,6) sequence
   function automatic word_type build_sequence();
      bit          used [64];
      int unsigned path [$];
      int unsigned popped [$];
      int unsigned v;
      int unsigned b;
      int unsigned i;
      bit          free0;
      bit          free1;
      word_type    seq;
      for (i = 0; i < 64; i++) begin
         used[i] = 1'b0;
      end
      path.push_back(0);
      while (path.size() != 0) begin
         v = path[$];
         free0 = !used[2 * v];
         free1 = !used[2 * v + 1];
         if (free0 || free1) begin
            if (free0 && free1) begin
               b = $urandom_range(0, 1);
            end else begin
               b = free1 ? 1 : 0;
            end
            used[2 * v + b] = 1'b1;
            path.push_back(((v << 1) | b) & 31);
         end else begin
            popped.push_back(v);
            void'(path.pop_back());
         end
      end
      for (i = 0; i < 64; i++) begin
         seq[i] = popped[i][0];
      end
      return seq;
   endfunction

   function automatic int unsigned pause_len();
      return quiet ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic note_mismatch(input string what, input word_type got, input word_type want);
      mismatch_count++;
      $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
   endtask

   task automatic send_word(input word_type w, input canon_result_type want);
      int unsigned gap;
      gap = pause_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      canon_due.push_back(want);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_draw = pause_len();
         stall_hold <= stall_draw;
         rsp_stall  <= (stall_draw != 0);
      end else if (stall_hold > 1) begin
         stall_hold <= stall_hold - 1;
         rsp_stall  <= 1'b1;
      end else begin
         stall_hold <= 0;
         rsp_stall  <= 1'b0;
      end
   end

   canon_result_type want_q;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (canon_due.size() == 0) begin
            note_mismatch("unexpected transaction", rsp_canonical, '0);
         end else begin
            want_q = canon_due.pop_front();
            if (rsp_canonical !== want_q.canonical) begin
               note_mismatch("canonical", rsp_canonical, want_q.canonical);
            end
            if (rsp_rotation !== want_q.rotation) begin
               note_mismatch("rotation", word_type'(rsp_rotation), word_type'(want_q.rotation));
            end
            if (rsp_is_valid !== want_q.is_valid) begin
               note_mismatch("is_valid", word_type'(rsp_is_valid), word_type'(want_q.is_valid));
            end
         end
      end
   end

   initial begin
      int unsigned      i;
      int unsigned      pick;
      word_type         w;
      stim_row_type     row;
      canon_result_type want;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[row_idx]) begin
         row = stim_table[row_idx];
         w = rotl(row.base, row.turn);
         if (row.invert) begin
            w = ~w;
         end
         w = w ^ row.flip;
         if (row.typed) begin
            want = '{row.canon, row.rot, row.ok};
         end else begin
            want = canonicalize_word(w);
         end
         send_word(w, want);
      end

      for (i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 125 == 0) begin
            quiet = ($urandom_range(0, 3) == 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            w = rotl(build_sequence(), $urandom_range(0, 63));
            if ($urandom_range(0, 1) == 1) begin
               w = ~w;
            end
         end else if (pick < 85) begin
            w = rotl(build_sequence(), $urandom_range(0, 63));
            w[$urandom_range(0, 63)] ^= 1'b1;
            if ($urandom_range(0, 1) == 1) begin
               w[$urandom_range(0, 63)] ^= 1'b1;
            end
         end else begin
            w = {$urandom, $urandom};
            if ($urandom_range(0, 2) == 0) begin
               w = w & {$urandom, $urandom} & {$urandom, $urandom};
            end
         end
         send_word(w, canonicalize_word(w));
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      while (canon_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (canon_due.size() != 0) begin
         note_mismatch("result never arrived", '0, canon_due[0].canonical);
      end
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
